/* hdl/camera_ray_generator_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef CAMERA_RAY_GENERATOR_UNIT_DEFINES_SVH
`define CAMERA_RAY_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CRG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CRG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/crg_pkg.sv */
package crg_pkg;

    localparam int LANE_W  = 18;
    localparam int VEC_W   = 3 * LANE_W;
    localparam int PIX_W   = 10;
    localparam int HALF_W  = 14;
    localparam int PROD_W  = 32;
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int DIVD_W  = 48;
    localparam int QUO_W   = 17;
    localparam int SQRT_STAGES = 32;
    localparam int DIR_ONE = 65536;
    localparam int ORG_MAX = 131071;
    localparam int ORG_MIN = -131072;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 1024;

    // forward z lane = 1.0 in Q3.14
    localparam logic [VEC_W-1:0] FORWARD_RESET = 54'h4000000000000;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_ORIGIN  = 3'd1,
        REG_FORWARD = 3'd2,
        REG_RIGHT   = 3'd3,
        REG_UP      = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic             parallel;
        logic [VEC_W-1:0] origin;
        logic [VEC_W-1:0] forward;
        logic [VEC_W-1:0] right_step;
        logic [VEC_W-1:0] up_step;
    } cfg_t;

    // Per-item data that rides alongside the normalize pipeline
    typedef struct packed {
        logic [2:0][LANE_W-1:0] org;
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
    } side_t;

    function automatic logic signed [LANE_W-1:0] lane(input logic [VEC_W-1:0] v, input int k);
        return $signed(v[k*LANE_W +: LANE_W]);
    endfunction

endpackage

/* hdl/crg_offset.sv */
module crg_offset #(
    parameter int SCREEN_WIDTH  = crg_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = crg_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [crg_pkg::PIX_W-1:0]                   pixel_col,
    input  logic [crg_pkg::PIX_W-1:0]                   pixel_row,
    input  crg_pkg::cfg_t                               cfg,
    output logic                                        out_valid,
    output logic [2:0][crg_pkg::PROD_W-1:0]             vec,
    output logic [2:0][crg_pkg::LANE_W-1:0]             org
);

    localparam int HALF_COL = SCREEN_WIDTH / 2;
    localparam int HALF_ROW = SCREEN_HEIGHT / 2;

    logic signed [crg_pkg::HALF_W-1:0] hc;
    logic signed [crg_pkg::HALF_W-1:0] hr;

    logic                               a_valid_reg;
    logic [2:0][crg_pkg::PROD_W-1:0]    pr_reg, pr_next;
    logic [2:0][crg_pkg::PROD_W-1:0]    pu_reg, pu_next;
    logic                               b_valid_reg;
    logic [2:0][crg_pkg::PROD_W-1:0]    vec_reg, vec_next;
    logic [2:0][crg_pkg::LANE_W-1:0]    org_reg, org_next;

    // Centered half-pixel offsets: 2*(idx - size/2) + 1
    assign hc = $signed({3'b000, pixel_col, 1'b1}) - crg_pkg::HALF_W'(2 * HALF_COL);
    assign hr = $signed({3'b000, pixel_row, 1'b1}) - crg_pkg::HALF_W'(2 * HALF_ROW);

    // Scale the steps by the offsets
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr_next[k] = 32'(crg_pkg::lane(cfg.right_step, k)) * 32'(hc);
            pu_next[k] = 32'(crg_pkg::lane(cfg.up_step, k)) * 32'(hr);
        end
    end

    // Combine offsets with forward or origin
    always_comb
    begin
        logic signed [33:0] off;
        logic signed [33:0] sum_p;
        logic signed [33:0] sum_o;
        logic signed [22:0] sh;
        off   = '0;
        sum_p = '0;
        sum_o = '0;
        sh    = '0;
        for (int k = 0; k < 3; k++)
        begin
            off   = 34'($signed(pr_reg[k])) + 34'($signed(pu_reg[k]));
            sum_p = (34'(crg_pkg::lane(cfg.forward, k)) <<< 7) + off;
            sum_o = (34'(crg_pkg::lane(cfg.origin, k)) <<< 11) + off + 34'sd1024;
            sh    = sum_o[33:11];
            if (cfg.parallel)
            begin
                vec_next[k] = 32'(crg_pkg::lane(cfg.forward, k));
                if (sh > 23'(crg_pkg::ORG_MAX))
                    org_next[k] = 18'h1FFFF;
                else if (sh < 23'(crg_pkg::ORG_MIN))
                    org_next[k] = 18'h20000;
                else
                    org_next[k] = sh[17:0];
            end
            else
            begin
                vec_next[k] = sum_p[31:0];
                org_next[k] = cfg.origin[k*crg_pkg::LANE_W +: crg_pkg::LANE_W];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg  <= pr_next;
            pu_reg  <= pu_next;
            vec_reg <= vec_next;
            org_reg <= org_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign vec       = vec_reg;
    assign org       = org_reg;

endmodule

/* hdl/crg_norm.sv */
module crg_norm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][crg_pkg::PROD_W-1:0]     vec,
    input  logic [2:0][crg_pkg::LANE_W-1:0]     org,
    output logic                                out_valid,
    output logic [crg_pkg::SQ_W-1:0]            sum,
    output crg_pkg::side_t                      side
);

    localparam int SHIFTS = 5;

    logic [SHIFTS:0]                    vld_reg;
    crg_pkg::side_t                     sd_reg  [SHIFTS+1];
    crg_pkg::side_t                     sd_next [SHIFTS+1];
    logic                               sq_valid_reg;
    crg_pkg::side_t                     sq_side_reg;
    logic [2:0][2*crg_pkg::MAG_W-1:0]   sq_reg, sq_next;
    logic                               sum_valid_reg;
    crg_pkg::side_t                     sum_side_reg;
    logic [crg_pkg::SQ_W-1:0]           sum_reg, sum_next;

    // Split into sign and magnitude
    always_comb
    begin
        logic [crg_pkg::PROD_W-1:0] nv;
        nv = '0;
        sd_next[0].org = org;
        for (int k = 0; k < 3; k++)
        begin
            nv = -vec[k];
            sd_next[0].neg[k] = vec[k][crg_pkg::PROD_W-1];
            sd_next[0].mag[k] = vec[k][crg_pkg::PROD_W-1] ? nv[crg_pkg::MAG_W-1:0]
                                                         : vec[k][crg_pkg::MAG_W-1:0];
        end
    end

    // Normalize: shift by 16, 8, 4, 2, 1 while the top bits are clear
    for (genvar i = 1; i <= SHIFTS; i++)
    begin : g_shift
        localparam int S = 1 << (SHIFTS - i);
        always_comb
        begin
            logic [crg_pkg::MAG_W-1:0] mx;
            mx = sd_reg[i-1].mag[0] | sd_reg[i-1].mag[1] | sd_reg[i-1].mag[2];
            sd_next[i] = sd_reg[i-1];
            if (mx[crg_pkg::MAG_W-1 -: S] == '0)
            begin
                for (int k = 0; k < 3; k++)
                    sd_next[i].mag[k] = sd_reg[i-1].mag[k] << S;
            end
        end
    end

    // Square each lane, then add
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sq_next[k] = (2*crg_pkg::MAG_W)'(sd_reg[SHIFTS].mag[k])
                       * (2*crg_pkg::MAG_W)'(sd_reg[SHIFTS].mag[k]);
        sum_next = crg_pkg::SQ_W'(sq_reg[0]) + crg_pkg::SQ_W'(sq_reg[1])
                 + crg_pkg::SQ_W'(sq_reg[2]);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[SHIFTS-1:0], in_valid};
            sq_valid_reg  <= vld_reg[SHIFTS];
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= SHIFTS; i++)
                sd_reg[i] <= sd_next[i];
            sq_reg       <= sq_next;
            sq_side_reg  <= sd_reg[SHIFTS];
            sum_reg      <= sum_next;
            sum_side_reg <= sq_side_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign side      = sum_side_reg;

endmodule

/* hdl/crg_isqrt.sv */
module crg_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [crg_pkg::SQ_W-1:0]    sum,
    input  crg_pkg::side_t              side_in,
    output logic                        out_valid,
    output logic [crg_pkg::ROOT_W-1:0]  root,
    output crg_pkg::side_t              side_out
);

    localparam int N = crg_pkg::SQRT_STAGES;

    logic [N-1:0]               vld_reg;
    logic [crg_pkg::SQ_W-1:0]   q_reg   [N];
    logic [crg_pkg::SQ_W-1:0]   q_next  [N];
    logic [crg_pkg::SQ_W-1:0]   res_reg [N];
    logic [crg_pkg::SQ_W-1:0]   res_next[N];
    crg_pkg::side_t             sd_reg  [N];
    logic [crg_pkg::SQ_W-1:0]   q_in    [N];
    logic [crg_pkg::SQ_W-1:0]   res_in  [N];
    crg_pkg::side_t             sd_in   [N];

    // One root bit per stage, restoring form
    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam logic [crg_pkg::SQ_W-1:0] BIT = crg_pkg::SQ_W'(1) << (2*N - 2 - 2*i);
        if (i == 0)
        begin : g_first
            assign q_in[i]   = sum;
            assign res_in[i] = '0;
            assign sd_in[i]  = side_in;
        end
        else
        begin : g_rest
            assign q_in[i]   = q_reg[i-1];
            assign res_in[i] = res_reg[i-1];
            assign sd_in[i]  = sd_reg[i-1];
        end
        always_comb
        begin
            logic [crg_pkg::SQ_W:0] t;
            t = {1'b0, res_in[i]} + {1'b0, BIT};
            if ({1'b0, q_in[i]} >= t)
            begin
                q_next[i]   = q_in[i] - t[crg_pkg::SQ_W-1:0];
                res_next[i] = (res_in[i] >> 1) + BIT;
            end
            else
            begin
                q_next[i]   = q_in[i];
                res_next[i] = res_in[i] >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                q_reg[i]   <= q_next[i];
                res_reg[i] <= res_next[i];
                sd_reg[i]  <= sd_in[i];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = res_reg[N-1][crg_pkg::ROOT_W-1:0];
    assign side_out  = sd_reg[N-1];

endmodule

/* hdl/crg_divide.sv */
module crg_divide (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [crg_pkg::ROOT_W-1:0]          root,
    input  crg_pkg::side_t                      side,
    output logic                                out_valid,
    output logic [2:0][crg_pkg::LANE_W-1:0]     dir,
    output logic [2:0][crg_pkg::LANE_W-1:0]     org
);

    localparam int N = crg_pkg::QUO_W;

    typedef struct packed {
        logic [2:0][crg_pkg::DIVD_W-1:0] rem;
        logic [2:0][N-1:0]               quo;
        logic [crg_pkg::ROOT_W-1:0]      n;
        logic [2:0]                      neg;
        logic [2:0][crg_pkg::LANE_W-1:0] org;
    } div_t;

    logic                               setup_valid_reg;
    div_t                               setup_reg, setup_next;
    logic [N-1:0]                       vld_reg;
    div_t                               st_reg  [N];
    div_t                               st_next [N];
    div_t                               st_in   [N];
    logic                               out_valid_reg;
    logic [2:0][crg_pkg::LANE_W-1:0]    dir_reg, dir_next;
    logic [2:0][crg_pkg::LANE_W-1:0]    org_reg;

    // Dividend: mag * 65536 + n/2
    always_comb
    begin
        setup_next.n   = root;
        setup_next.neg = side.neg;
        setup_next.org = side.org;
        setup_next.quo = '0;
        for (int k = 0; k < 3; k++)
            setup_next.rem[k] = crg_pkg::DIVD_W'({side.mag[k], 16'h0000})
                              + crg_pkg::DIVD_W'(root[crg_pkg::ROOT_W-1:1]);
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < N; j++)
    begin : g_step
        localparam int SH = N - 1 - j;
        if (j == 0)
        begin : g_first
            assign st_in[j] = setup_reg;
        end
        else
        begin : g_rest
            assign st_in[j] = st_reg[j-1];
        end
        always_comb
        begin
            logic [crg_pkg::DIVD_W:0] d;
            d = (crg_pkg::DIVD_W+1)'(st_in[j].n) << SH;
            st_next[j] = st_in[j];
            for (int k = 0; k < 3; k++)
            begin
                if ({1'b0, st_in[j].rem[k]} >= d)
                begin
                    st_next[j].rem[k]     = st_in[j].rem[k] - d[crg_pkg::DIVD_W-1:0];
                    st_next[j].quo[k][SH] = 1'b1;
                end
            end
        end
    end

    // Clamp, apply sign, zero for a zero-length vector
    always_comb
    begin
        logic [N-1:0] qv;
        qv = '0;
        for (int k = 0; k < 3; k++)
        begin
            qv = st_reg[N-1].quo[k];
            if (qv > N'(crg_pkg::DIR_ONE))
                qv = N'(crg_pkg::DIR_ONE);
            if (st_reg[N-1].n == '0)
                dir_next[k] = '0;
            else if (st_reg[N-1].neg[k])
                dir_next[k] = -crg_pkg::LANE_W'(qv);
            else
                dir_next[k] = crg_pkg::LANE_W'(qv);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            setup_valid_reg <= in_valid;
            vld_reg         <= {vld_reg[N-2:0], setup_valid_reg};
            out_valid_reg   <= vld_reg[N-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setup_reg <= setup_next;
            for (int j = 0; j < N; j++)
                st_reg[j] <= st_next[j];
            dir_reg <= dir_next;
            org_reg <= st_reg[N-1].org;
        end
    end

    assign out_valid = out_valid_reg;
    assign dir       = dir_reg;
    assign org       = org_reg;

endmodule

/* hdl/camera_ray_generator_unit.sv */
// Pinhole camera primary ray generator. Each input item is one pixel (column, row);
// each output item is one ray: origin (Q7.10, saturated) and unit direction (Q1.16).
// The block takes one item every clock while the output is not held, and passes it
// through the pixel offsets, normalizing and squaring, the square root (one root bit
// per stage) and the three lane divisions (one quotient bit per stage).
// When the output is held, the whole pipeline holds and s_tready drops. Write the
// configuration registers only while no item is in flight.
module camera_ray_generator_unit #(
    parameter int SCREEN_WIDTH  = crg_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = crg_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,    // pixel_col, pixel_row, zero pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    output logic [111:0]                m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [crg_pkg::VEC_W-1:0]   cfg_data
);

    crg_pkg::cfg_t                          cfg_reg;
    logic                                   en;
    logic                                   off_valid;
    logic [2:0][crg_pkg::PROD_W-1:0]        off_vec;
    logic [2:0][crg_pkg::LANE_W-1:0]        off_org;
    logic                                   norm_valid;
    logic [crg_pkg::SQ_W-1:0]               norm_sum;
    crg_pkg::side_t                         norm_side;
    logic                                   sqrt_valid;
    logic [crg_pkg::ROOT_W-1:0]             sqrt_root;
    crg_pkg::side_t                         sqrt_side;
    logic [2:0][crg_pkg::LANE_W-1:0]        ray_dir;
    logic [2:0][crg_pkg::LANE_W-1:0]        ray_org;

    // Advance the pipeline unless a result waits at the output
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.parallel   <= 1'b0;
            cfg_reg.origin     <= '0;
            cfg_reg.forward    <= crg_pkg::FORWARD_RESET;
            cfg_reg.right_step <= '0;
            cfg_reg.up_step    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                crg_pkg::REG_MODE:    cfg_reg.parallel   <= cfg_data[0];
                crg_pkg::REG_ORIGIN:  cfg_reg.origin     <= cfg_data;
                crg_pkg::REG_FORWARD: cfg_reg.forward    <= cfg_data;
                crg_pkg::REG_RIGHT:   cfg_reg.right_step <= cfg_data;
                crg_pkg::REG_UP:      cfg_reg.up_step    <= cfg_data;
                default:              cfg_reg            <= cfg_reg;
            endcase
        end
    end

    crg_offset #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel_col (s_tdata[9:0]),
        .pixel_row (s_tdata[19:10]),
        .cfg       (cfg_reg),
        .out_valid (off_valid),
        .vec       (off_vec),
        .org       (off_org)
    );

    crg_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (off_valid),
        .vec       (off_vec),
        .org       (off_org),
        .out_valid (norm_valid),
        .sum       (norm_sum),
        .side      (norm_side)
    );

    crg_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .sum       (norm_sum),
        .side_in   (norm_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    crg_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .side      (sqrt_side),
        .out_valid (m_tvalid),
        .dir       (ray_dir),
        .org       (ray_org)
    );

    assign m_tdata = {4'b0000, ray_dir[2], ray_dir[1], ray_dir[0],
                      ray_org[2], ray_org[1], ray_org[0]};

endmodule

/* hdl/crg_checker.sv */
`include "camera_ray_generator_unit_defines.svh"

module crg_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [23:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
    logic               in_seen;
    logic               dir_ok;

    assign dx      = m_tdata[71:54];
    assign dy      = m_tdata[89:72];
    assign dz      = m_tdata[107:90];
    assign in_seen = s_tvalid;

    // Each direction lane within [-1.0, 1.0] in Q1.16
    assign dir_ok  = dx >= -18'sd65536 && dx <= 18'sd65536
                  && dy >= -18'sd65536 && dy <= 18'sd65536
                  && dz >= -18'sd65536 && dz <= 18'sd65536;

    // A held result keeps its value
    `CRG_ASSERT_NXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An empty output never blocks the input side
    `CRG_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)

    // A full, stalled output blocks the input side
    `CRG_ASSERT_IMP(a_block_when_full, in_seen && m_tvalid && !m_tready, !s_tready)

    // Direction lanes stay within a unit vector
    `CRG_ASSERT_IMP(a_dir_bound, m_tvalid, dir_ok)

endmodule

bind camera_ray_generator_unit crg_checker u_checker (.*);
